// ----- rtl/core/mscic_pkg.sv -----
package mscic_pkg;

	// Fixed field widths.
	localparam int DATA_W = 32;
	localparam int INV_W  = 11;

	// Default store depth.
	localparam int MAX_ELEMENTS_DEF = 64;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SEG,
		ST_GETL,
		ST_GETR,
		ST_MERGE,
		ST_FILLL,
		ST_FILLR,
		ST_OREAD,
		ST_OWAIT,
		ST_OHOLD
	} state_t;

endpackage

// ----- rtl/core/mscic_ram.sv -----
module mscic_ram
	import mscic_pkg::*;
#(
	parameter int WIDTH = DATA_W,
	parameter int DEPTH = MAX_ELEMENTS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/merge_sort_inversion_count_core.sv -----
// Merge sort with inversion count.
// Input channel (value, is_last, in_valid/in_ready): signed values are loaded
// one item per cycle into the first memory. The item with is_last set, or the
// item that fills the store to MAX_ELEMENTS, starts the sort; one item skips it.
// The sort runs bottom-up merge passes of width 1, 2, 4 and so on, reading one
// memory and writing the other, so the two memories swap roles each pass.
// With one read port, a merge step writes one element and, if its run has more,
// refetches that run's next head; each segment first fetches both run heads.
// Output channel (sorted_value, inversion_count, last_out, out_valid/out_ready):
// one item per element in ascending order, each carrying the total inversion
// count; last_out marks the final one. Each result is read from memory into the
// output register, and the block holds it for as long as out_ready is low.
// No input item is taken from the start of the sort until the last result is
// accepted. After reset the block waits for the first item of a new sequence;
// the memories are not cleared, since only entries written in the run are read.
module merge_sort_inversion_count_core
	import mscic_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     is_last,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] sorted_value,
	output logic [INV_W-1:0]         inversion_count,
	output logic                     last_out
);

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);

	state_t state_q, state_d;

	logic [CW-1:0] cnt_q, n_q, lo_q, mid_q, hi_q, i_q, j_q, k_q;
	logic [CW:0]   w_q;
	logic          src_sel_q;
	logic [INV_W-1:0] inv_q;
	logic signed [DATA_W-1:0] left_q, right_q, out_val_q;
	logic          out_last_q;

	// Memory ports.
	logic              we_a, we_b;
	logic [AW-1:0]     waddr, raddr;
	logic [DATA_W-1:0] wdata, rdata_a, rdata_b, rdata;

	mscic_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_ram_a (
		.clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata_a)
	);

	mscic_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_ram_b (
		.clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata_b)
	);

	assign rdata = src_sel_q ? rdata_b : rdata_a;

	// Load bookkeeping.
	logic          accept;
	logic [CW-1:0] cnt_inc;
	logic          load_done;

	assign accept    = in_valid && in_ready;
	assign cnt_inc   = cnt_q + 1'b1;
	assign load_done = is_last || (cnt_inc == CW'(MAX_ELEMENTS));

	// Segment bounds for the next merge, clipped to the run length.
	logic [CW+1:0] sum_mid, sum_hi, n_ext;
	logic [CW-1:0] mid_d, hi_d;

	assign sum_mid = {2'b00, lo_q} + {1'b0, w_q};
	assign sum_hi  = {2'b00, lo_q} + {w_q, 1'b0};
	assign n_ext   = {2'b00, n_q};
	assign mid_d   = (sum_mid > n_ext) ? n_q : sum_mid[CW-1:0];
	assign hi_d    = (sum_hi > n_ext) ? n_q : sum_hi[CW-1:0];

	// Merge decision: ties take the left run.
	logic          l_ok, r_ok, take_left, seg_end, pass_end;
	logic [CW-1:0] i_inc, j_inc, k_inc;
	logic [CW:0]   w_dbl;

	assign l_ok      = i_q < mid_q;
	assign r_ok      = j_q < hi_q;
	assign take_left = l_ok && (!r_ok || (left_q <= right_q));
	assign i_inc     = i_q + 1'b1;
	assign j_inc     = j_q + 1'b1;
	assign k_inc     = k_q + 1'b1;
	assign seg_end   = k_inc == hi_q;
	assign pass_end  = hi_q == n_q;
	assign w_dbl     = {w_q[CW-1:0], 1'b0};

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory control.
	always_comb begin
		state_d = state_q;
		we_a    = 1'b0;
		we_b    = 1'b0;
		waddr   = k_q[AW-1:0];
		wdata   = take_left ? left_q : right_q;
		raddr   = k_q[AW-1:0];
		case (state_q)
			ST_LOAD: begin
				waddr = cnt_q[AW-1:0];
				wdata = value;
				if (accept) begin
					we_a = 1'b1;
					if (load_done) begin
						state_d = (cnt_inc == CW'(1)) ? ST_OREAD : ST_SEG;
					end
				end
			end
			ST_SEG: begin
				raddr   = lo_q[AW-1:0];
				state_d = ST_GETL;
			end
			ST_GETL: begin
				raddr   = mid_q[AW-1:0];
				state_d = ST_GETR;
			end
			ST_GETR: begin
				state_d = ST_MERGE;
			end
			ST_MERGE: begin
				we_a = src_sel_q;
				we_b = !src_sel_q;
				if (seg_end) begin
					if (pass_end && (w_dbl >= {1'b0, n_q})) begin
						state_d = ST_OREAD;
					end else begin
						state_d = ST_SEG;
					end
				end else if (take_left) begin
					raddr   = i_inc[AW-1:0];
					state_d = (i_inc < mid_q) ? ST_FILLL : ST_MERGE;
				end else begin
					raddr   = j_inc[AW-1:0];
					state_d = (j_inc < hi_q) ? ST_FILLR : ST_MERGE;
				end
			end
			ST_FILLL: begin
				state_d = ST_MERGE;
			end
			ST_FILLR: begin
				state_d = ST_MERGE;
			end
			ST_OREAD: begin
				state_d = ST_OWAIT;
			end
			ST_OWAIT: begin
				state_d = ST_OHOLD;
			end
			ST_OHOLD: begin
				if (out_ready) begin
					state_d = out_last_q ? ST_LOAD : ST_OREAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// Counters, indices and the inversion counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			n_q       <= '0;
			lo_q      <= '0;
			mid_q     <= '0;
			hi_q      <= '0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			w_q       <= '0;
			src_sel_q <= 1'b0;
			inv_q     <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						cnt_q <= cnt_inc;
						if (load_done) begin
							n_q       <= cnt_inc;
							w_q       <= (CW+1)'(1);
							lo_q      <= '0;
							k_q       <= '0;
							src_sel_q <= 1'b0;
						end
					end
				end
				ST_SEG: begin
					mid_q <= mid_d;
					hi_q  <= hi_d;
					i_q   <= lo_q;
					j_q   <= mid_d;
					k_q   <= lo_q;
				end
				ST_MERGE: begin
					k_q <= k_inc;
					if (take_left) begin
						i_q <= i_inc;
					end else begin
						j_q   <= j_inc;
						inv_q <= inv_q + INV_W'(mid_q - i_q);
					end
					if (seg_end) begin
						if (pass_end) begin
							lo_q      <= '0;
							w_q       <= w_dbl;
							src_sel_q <= !src_sel_q;
							k_q       <= '0;
						end else begin
							lo_q <= hi_q;
						end
					end
				end
				ST_OHOLD: begin
					if (out_ready) begin
						if (out_last_q) begin
							cnt_q <= '0;
							inv_q <= '0;
						end else begin
							k_q <= k_inc;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Run heads and the output register.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_GETL, ST_FILLL: begin
				left_q <= rdata;
			end
			ST_GETR, ST_FILLR: begin
				right_q <= rdata;
			end
			ST_OWAIT: begin
				out_val_q  <= rdata;
				out_last_q <= k_inc == n_q;
			end
			default: begin
			end
		endcase
	end

	assign in_ready        = state_q == ST_LOAD;
	assign out_valid       = state_q == ST_OHOLD;
	assign sorted_value    = out_val_q;
	assign inversion_count = inv_q;
	assign last_out        = out_last_q;

	// The two channels are never open at once.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input and output open together");

	// Every element written so far came from exactly one of the two runs.
	a_merge_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |->
		({1'b0, k_q} + {1'b0, mid_q}) == ({1'b0, i_q} + {1'b0, j_q}))
		else $error("merge indices out of step");

	// A new sequence starts with a cleared counter.
	a_inv_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (inv_q == '0))
		else $error("inversion counter not cleared");

	// The final result hands the block back to loading.
	a_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_out) |=> (in_ready && (cnt_q == '0)))
		else $error("block did not return to loading");

endmodule
